[design/phnm_pkg.sv]
// ----------------------------------------------------------------------------
// phnm_pkg
// shared sizes and constants of the periodic hot node marker
// ----------------------------------------------------------------------------
`default_nettype none

package phnm_pkg;

   localparam int NODES   = 16;
   localparam int NODE_W  = $clog2(NODES);
   localparam int CNT_W   = $clog2(NODES + 1);
   localparam int DATA_W  = 32;
   localparam int IDX_W   = 4;
   localparam int NCFG_W  = 5;

   localparam logic [DATA_W-1:0] SAT_MAX        = '1;
   localparam logic [DATA_W-1:0] INTERVAL_RESET = 32'd1000;
   localparam logic [NCFG_W-1:0] NODE_CNT_RESET = 5'd16;

   localparam logic CSR_INTERVAL   = 1'b0;
   localparam logic CSR_NODE_COUNT = 1'b1;

   localparam logic MODE_ACCESS = 1'b0;

endpackage

`default_nettype wire

[design/periodic_hot_node_marker.sv]
// ----------------------------------------------------------------------------
// periodic_hot_node_marker
// per-node access counters in a ram; every interval ticks a sweep
// reports each walked node with a hot flag for the nodes at the top count
// ----------------------------------------------------------------------------
// access transaction: accepted every cycle while idle, busy stays low, counter written
//   back in the next cycle through a read-modify-write with forwarding
// tick transaction: busy in the bit-serial remainder unit; a sweep follows only when
//   the incremented tick count leaves no remainder by the interval
// sweep: two passes over the counter ram read port, first the maximum then the results,
//   results one per cycle on rsp_valid in node order; receiver cannot stall
// reset: counters read as zero at once through per-entry valid bits
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_hot_node_marker
   import phnm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic              req_mode,
   input  wire logic [IDX_W-1:0]  req_node_index,
   output logic                   rsp_valid,
   output logic [IDX_W-1:0]       rsp_node_number,
   output logic                   rsp_hot,
   output logic [DATA_W-1:0]      rsp_access_count,
   output logic                   rsp_last,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [DATA_W-1:0] csr_wdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_MAX  = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [DATA_W-1:0] interval_ff;
   logic [NCFG_W-1:0] node_count_ff;
   logic [DATA_W-1:0] total_ff, total_in;
   logic [DATA_W-1:0] tick_ff, tick_in;
   logic [NODES-1:0]  valid_ff, valid_in;

   logic              s1_v_ff;
   logic [NODE_W-1:0] s1_addr_ff;
   logic              lw_v_ff;
   logic [NODE_W-1:0] lw_addr_ff;
   logic [DATA_W-1:0] lw_data_ff;
   logic              rdv_ff;

   logic [DATA_W-1:0] num_ff, num_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [4:0]        div_cnt_ff, div_cnt_in;

   logic [CNT_W-1:0]  a_ff, a_in;
   logic              pv_ff, pv_in;
   logic [NODE_W-1:0] pa_ff, pa_in;
   logic [DATA_W-1:0] max_ff, max_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_num_ff, rsp_num_in;
   logic              rsp_hot_ff, rsp_hot_in;
   logic [DATA_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              accept;
   logic              acc_ok;
   logic [NODE_W-1:0] rd_addr;
   logic [DATA_W-1:0] ram_rdata;
   logic [DATA_W-1:0] rd_val;
   logic [DATA_W-1:0] cur;
   logic [DATA_W-1:0] inc;
   logic [CNT_W-1:0]  walk;
   logic [DATA_W:0]   sh;
   logic [DATA_W:0]   rnew;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign acc_ok = accept && (req_mode == MODE_ACCESS)
                   && (32'(req_node_index) < NODES);

   assign walk = (32'(node_count_ff) > NODES) ? CNT_W'(NODES) : CNT_W'(node_count_ff);

   assign rd_addr = (state_ff == ST_IDLE) ? NODE_W'(req_node_index) : a_ff[NODE_W-1:0];
   assign rd_val  = rdv_ff ? ram_rdata : '0;

   // forward the write of the previous cycle, which the ram read missed
   assign cur = (lw_v_ff && (lw_addr_ff == s1_addr_ff)) ? lw_data_ff : rd_val;
   assign inc = (cur == SAT_MAX) ? cur : cur + DATA_W'(1);

   assign sh   = {rem_ff, num_ff[DATA_W-1]};
   assign rnew = (sh >= {1'b0, interval_ff}) ? (sh - {1'b0, interval_ff}) : sh;

   phnm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (NODES)
   ) u_cnt_ram (
      .clock (clock),
      .we    (s1_v_ff),
      .waddr (s1_addr_ff),
      .wdata (inc),
      .raddr (rd_addr),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      tick_in      = tick_ff;
      valid_in     = valid_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      a_in         = a_ff;
      pv_in        = 1'b0;
      pa_in        = pa_ff;
      max_in       = max_ff;
      rsp_valid_in = 1'b0;
      rsp_num_in   = rsp_num_ff;
      rsp_hot_in   = rsp_hot_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_last_in  = rsp_last_ff;

      if (s1_v_ff) begin
         valid_in[s1_addr_ff] = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (acc_ok && (total_ff != SAT_MAX)) begin
               total_in = total_ff + DATA_W'(1);
            end
            if (accept && (req_mode != MODE_ACCESS)) begin
               tick_in = tick_ff + DATA_W'(1);
               if (interval_ff != '0) begin
                  state_in   = ST_DIV;
                  num_in     = tick_ff + DATA_W'(1);
                  rem_in     = '0;
                  div_cnt_in = '0;
               end
            end
         end
         ST_DIV: begin
            rem_in     = rnew[DATA_W-1:0];
            num_in     = {num_ff[DATA_W-2:0], 1'b0};
            div_cnt_in = div_cnt_ff + 5'd1;
            if (div_cnt_ff == 5'd31) begin
               a_in   = '0;
               max_in = '0;
               state_in = (rnew[DATA_W-1:0] == '0) ? ST_MAX : ST_IDLE;
            end
         end
         ST_MAX: begin
            if (a_ff < walk) begin
               pv_in = 1'b1;
               pa_in = a_ff[NODE_W-1:0];
               a_in  = a_ff + CNT_W'(1);
            end
            if (pv_ff && (rd_val > max_ff)) begin
               max_in = rd_val;
            end
            if ((a_ff >= walk) && !pv_ff) begin
               a_in     = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (a_ff < walk) begin
               pv_in = 1'b1;
               pa_in = a_ff[NODE_W-1:0];
               a_in  = a_ff + CNT_W'(1);
            end
            if (pv_ff) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = IDX_W'(pa_ff);
               rsp_hot_in   = (total_ff != '0) && (rd_val == max_ff);
               rsp_cnt_in   = rd_val;
               rsp_last_in  = ((CNT_W'(pa_ff) + CNT_W'(1)) == walk);
            end
            if ((a_ff >= walk) && !pv_ff) begin
               total_in = '0;
               valid_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         interval_ff   <= INTERVAL_RESET;
         node_count_ff <= NODE_CNT_RESET;
         total_ff      <= '0;
         tick_ff       <= '0;
         valid_ff      <= '0;
         s1_v_ff       <= 1'b0;
         lw_v_ff       <= 1'b0;
         pv_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         tick_ff      <= tick_in;
         valid_ff     <= valid_in;
         s1_v_ff      <= acc_ok;
         lw_v_ff      <= s1_v_ff;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_INTERVAL:   interval_ff   <= csr_wdata;
               CSR_NODE_COUNT: node_count_ff <= csr_wdata[NCFG_W-1:0];
               default:        ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff  <= NODE_W'(req_node_index);
      lw_addr_ff  <= s1_addr_ff;
      lw_data_ff  <= inc;
      rdv_ff      <= valid_ff[rd_addr];
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      div_cnt_ff  <= div_cnt_in;
      a_ff        <= a_in;
      pa_ff       <= pa_in;
      max_ff      <= max_in;
      rsp_num_ff  <= rsp_num_in;
      rsp_hot_ff  <= rsp_hot_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_node_number  = rsp_num_ff;
   assign rsp_hot          = rsp_hot_ff;
   assign rsp_access_count = rsp_cnt_ff;
   assign rsp_last         = rsp_last_ff;

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == ST_EMIT))
      else $error("result outside of emit pass");

   a_total_cleared: assert property (@(posedge clock) disable iff (reset)
      (($past(state_ff) == ST_EMIT) && (state_ff == ST_IDLE)) |-> (total_ff == '0))
      else $error("total not cleared after sweep");

   a_access_when_idle: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff |-> ($past(state_ff) == ST_IDLE))
      else $error("access write-back without idle accept");

   a_no_pass_read_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |=> !pv_ff)
      else $error("sweep read pending after idle");

endmodule

`default_nettype wire

[design/phnm_ram.sv]
// ----------------------------------------------------------------------------
// phnm_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module phnm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire
